[sv/ggrr_pkg.sv]
// ----------------------------------------------------------------------------
// ggrr_pkg
// Shared constants and codes for the granular grain ring resampler.
// ----------------------------------------------------------------------------
package ggrr_pkg;

  // Default geometry of the grain ring
  localparam int DEF_GRAIN_COUNT   = 8;
  localparam int DEF_MAX_GRAIN_LEN = 4096;

  // Field and register widths
  localparam int SAMPLE_W  = 16;
  localparam int FRAC_W    = 16;
  localparam int GS_REG_W  = 13;
  localparam int SPEED_W   = 19;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 19;

  // Smallest grain size in use
  localparam int MIN_GRAIN = 16;

  // Register reset values
  localparam logic [GS_REG_W-1:0] GS_RESET    = 13'd4096;
  localparam logic [SPEED_W-1:0]  SPEED_RESET = 19'd65536;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRAIN_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED      = 1'b1;

  // Word kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

endpackage

[sv/ggrr_queue.sv]
// ----------------------------------------------------------------------------
// ggrr_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module ggrr_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] ent_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[sv/ggrr_front.sv]
// ----------------------------------------------------------------------------
// ggrr_front
// Accepts words, holds config and ring pointers, emits store commands.
// ----------------------------------------------------------------------------
module ggrr_front #(
  parameter int GRAIN_COUNT   = 8,
  parameter int MAX_GRAIN_LEN = 4096,
  parameter int CMD_W         = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_kind,
  input  logic signed [ggrr_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                               cfg_valid,
  input  logic [ggrr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ggrr_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  logic                               q_full,
  input  logic                               clr_busy,
  output logic                               q_push,
  output logic [CMD_W-1:0]                   q_data
);
  import ggrr_pkg::*;

  localparam int POS_W   = $clog2(MAX_GRAIN_LEN);
  localparam int PW1     = POS_W + 1;
  localparam int GRAIN_W = $clog2(GRAIN_COUNT);
  localparam int AW      = $clog2(GRAIN_COUNT * MAX_GRAIN_LEN);
  localparam int RP_W    = POS_W + FRAC_W;
  localparam int SW      = RP_W + 1;
  localparam int CW      = (PW1 > GS_REG_W) ? PW1 : GS_REG_W;

  logic [GS_REG_W-1:0] gsize_r;
  logic [SPEED_W-1:0]  speed_r;
  logic [POS_W-1:0]    wpos_r, wpos_nxt;
  logic [GRAIN_W-1:0]  wgrain_r, wgrain_nxt;
  logic [RP_W-1:0]     rpos_r, rpos_nxt;
  logic [GRAIN_W-1:0]  rgrain_r, rgrain_nxt;

  logic [CW-1:0]       gs_wide;
  logic [PW1-1:0]      gs;
  logic [PW1-1:0]      wpos_inc;
  logic [POS_W-1:0]    cur;
  logic [FRAC_W-1:0]   frac;
  logic [PW1-1:0]      nxt_w;
  logic [POS_W-1:0]    nxt;
  logic [SW-1:0]       rsum;
  logic [SW-1:0]       rwrap;
  logic                accept;
  logic                rd_wrap;
  logic [AW-1:0]       addr0, addr1;

  function automatic logic [AW-1:0] ring_addr(input logic [GRAIN_W-1:0] g,
                                              input logic [POS_W-1:0]   p);
    return AW'(g) * AW'(MAX_GRAIN_LEN) + AW'(p);
  endfunction

  function automatic logic [GRAIN_W-1:0] grain_inc(input logic [GRAIN_W-1:0] g);
    return (g == GRAIN_W'(GRAIN_COUNT - 1)) ? '0 : g + 1'b1;
  endfunction

  assign in_stall = q_full | clr_busy;
  assign accept   = in_valid & ~in_stall;
  assign q_push   = accept;

  // grain size clamped to [MIN_GRAIN, MAX_GRAIN_LEN]
  always_comb begin
    gs_wide = CW'(gsize_r);
    if (gs_wide < CW'(MIN_GRAIN)) begin
      gs_wide = CW'(MIN_GRAIN);
    end else if (gs_wide > CW'(MAX_GRAIN_LEN)) begin
      gs_wide = CW'(MAX_GRAIN_LEN);
    end
    gs = PW1'(gs_wide);
  end

  always_comb begin
    // write pointer
    wpos_inc   = {1'b0, wpos_r} + 1'b1;
    wpos_nxt   = POS_W'(wpos_inc);
    wgrain_nxt = wgrain_r;
    if (wpos_inc >= gs) begin
      wpos_nxt   = '0;
      wgrain_nxt = grain_inc(wgrain_r);
    end

    // read side: neighbor index wraps inside the grain
    cur   = rpos_r[RP_W-1:FRAC_W];
    frac  = rpos_r[FRAC_W-1:0];
    nxt_w = {1'b0, cur} + 1'b1;
    if (nxt_w >= gs) begin
      nxt_w = nxt_w - gs;
    end
    if (nxt_w >= PW1'(MAX_GRAIN_LEN)) begin
      nxt_w = '0;
    end
    nxt = POS_W'(nxt_w);

    rsum    = {1'b0, rpos_r} + SW'(speed_r);
    rd_wrap = (rsum[SW-1:FRAC_W] >= gs);
    rwrap   = rsum - {gs, {FRAC_W{1'b0}}};
    rpos_nxt   = rd_wrap ? RP_W'(rwrap) : RP_W'(rsum);
    rgrain_nxt = rd_wrap ? grain_inc(rgrain_r) : rgrain_r;

    addr0 = (in_kind == KIND_READ) ? ring_addr(rgrain_r, cur)
                                   : ring_addr(wgrain_r, wpos_r);
    addr1 = ring_addr(rgrain_r, nxt);
    q_data = {in_kind, addr0, addr1, frac, in_sample_in};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gsize_r  <= GS_RESET;
      speed_r  <= SPEED_RESET;
      wpos_r   <= '0;
      wgrain_r <= '0;
      rpos_r   <= '0;
      rgrain_r <= GRAIN_W'(GRAIN_COUNT - 1);
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_GRAIN_SIZE: gsize_r <= cfg_data[GS_REG_W-1:0];
          CFG_SPEED:      speed_r <= cfg_data[SPEED_W-1:0];
          default:        ;
        endcase
      end
      if (accept && in_kind == KIND_WRITE) begin
        wpos_r   <= wpos_nxt;
        wgrain_r <= wgrain_nxt;
      end
      if (accept && in_kind == KIND_READ) begin
        rpos_r   <= rpos_nxt;
        rgrain_r <= rgrain_nxt;
      end
    end
  end

  a_rpos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, rpos_r[RP_W-1:FRAC_W]} < PW1'(MAX_GRAIN_LEN)))
    else $error("read position beyond grain storage");

  a_grains_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wgrain_r <= GRAIN_W'(GRAIN_COUNT - 1)) && (rgrain_r <= GRAIN_W'(GRAIN_COUNT - 1)))
    else $error("grain pointer beyond ring");

endmodule

[sv/ggrr_back.sv]
// ----------------------------------------------------------------------------
// ggrr_back
// Sample store, reset clear pass and interpolation pipeline.
// ----------------------------------------------------------------------------
module ggrr_back #(
  parameter int GRAIN_COUNT   = 8,
  parameter int MAX_GRAIN_LEN = 4096,
  parameter int CMD_W         = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  input  logic [CMD_W-1:0]                     q_data,
  output logic                                 q_pop,
  output logic                                 clr_busy,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [ggrr_pkg::SAMPLE_W-1:0] out_sample_out
);
  import ggrr_pkg::*;

  localparam int DEPTH = GRAIN_COUNT * MAX_GRAIN_LEN;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = 2 * SAMPLE_W + 2;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  logic                 clr_active_r;
  logic [AW-1:0]        clr_addr_r;

  logic                 c_kind;
  logic [AW-1:0]        c_addr0, c_addr1;
  logic [FRAC_W-1:0]    c_frac;
  logic [SAMPLE_W-1:0]  c_sample;

  logic                 adv;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [SAMPLE_W-1:0]  mem_wdata;

  logic                 s1_valid_r;
  logic [FRAC_W-1:0]    s1_frac_r;
  logic [SAMPLE_W-1:0]  rd_a_r, rd_b_r;
  logic                 s2_valid_r;
  logic signed [PW-1:0] prod_r;
  logic [SAMPLE_W-1:0]  s2_a_r;
  logic                 out_valid_r;
  logic [SAMPLE_W-1:0]  out_sample_r;

  logic signed [SAMPLE_W:0] diff;
  logic signed [PW-1:0]     prod;
  logic signed [PW-1:0]     acc;
  logic [SAMPLE_W-1:0]      quo;

  assign {c_kind, c_addr0, c_addr1, c_frac, c_sample} = q_data;

  // whole pipe moves together; held only by a stalled result
  assign adv      = ~out_valid_r | ~out_stall;
  assign q_pop    = ~q_empty & adv & ~clr_active_r;
  assign clr_busy = clr_active_r;

  assign mem_we    = clr_active_r | (q_pop & (c_kind == KIND_WRITE));
  assign mem_waddr = clr_active_r ? clr_addr_r : c_addr0;
  assign mem_wdata = clr_active_r ? '0 : c_sample;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (adv) begin
      rd_a_r <= mem[c_addr0];
      rd_b_r <= mem[c_addr1];
    end
  end

  // a + f*(b-a)/65536: one multiply, then sum and truncate toward zero
  always_comb begin
    diff = $signed({rd_b_r[SAMPLE_W-1], rd_b_r}) - $signed({rd_a_r[SAMPLE_W-1], rd_a_r});
    prod = $signed({1'b0, s1_frac_r}) * diff;
    acc  = $signed({{2{s2_a_r[SAMPLE_W-1]}}, s2_a_r, {FRAC_W{1'b0}}}) + prod_r;
    quo  = acc[FRAC_W+SAMPLE_W-1:FRAC_W]
         + SAMPLE_W'(acc[PW-1] & (|acc[FRAC_W-1:0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      if (adv) begin
        s1_valid_r  <= q_pop & (c_kind == KIND_READ);
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_frac_r    <= c_frac;
      prod_r       <= prod;
      s2_a_r       <= rd_a_r;
      out_sample_r <= quo;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !q_pop)
    else $error("command taken during clear pass");

  a_read_flows: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_valid_r) |=> s2_valid_r)
    else $error("read lost between pipeline stages");

endmodule

[sv/granular_grain_ring_resampler_top.sv]
// ----------------------------------------------------------------------------
// granular_grain_ring_resampler_top
// Grain ring sample store with linearly interpolated, speed-stepped reads.
// ----------------------------------------------------------------------------
// Write words store a sample at the write pointer, which walks through a grain
// of grain_size samples and then moves to the next grain of the ring. Read
// words return one sample interpolated between two neighbors of the current
// read grain at a Q16 position, then step the position by speed (Q3.16) and
// roll into the next grain at the grain end. Throughput is one word per clock
// while in_stall is low: the front updates the pointers and builds store
// addresses in the cycle it takes a word; the back does one store access per
// cycle (one write, or two reads on the dual-read store). A read result passes
// the queue and the read, product and output registers. After reset the store
// is zeroed one entry per cycle, GRAIN_COUNT * MAX_GRAIN_LEN entries (32768 by
// default); in_stall stays high meanwhile, config writes are taken throughout.
// ----------------------------------------------------------------------------
module granular_grain_ring_resampler_top #(
  parameter int GRAIN_COUNT   = ggrr_pkg::DEF_GRAIN_COUNT,
  parameter int MAX_GRAIN_LEN = ggrr_pkg::DEF_MAX_GRAIN_LEN
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input words
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_kind,
  input  logic signed [ggrr_pkg::SAMPLE_W-1:0] in_sample_in,
  // result words
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [ggrr_pkg::SAMPLE_W-1:0] out_sample_out,
  // register writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ggrr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ggrr_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import ggrr_pkg::*;

  localparam int AW    = $clog2(GRAIN_COUNT * MAX_GRAIN_LEN);
  // command: kind, two store addresses, fraction, sample
  localparam int CMD_W = 1 + 2 * AW + FRAC_W + SAMPLE_W;

  logic             q_push, q_pop, q_full, q_empty;
  logic [CMD_W-1:0] q_wdata, q_rdata;
  logic             clr_busy;

  // registers are always writable
  assign cfg_ready = 1'b1;

  ggrr_front #(
    .GRAIN_COUNT  (GRAIN_COUNT),
    .MAX_GRAIN_LEN(MAX_GRAIN_LEN),
    .CMD_W        (CMD_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_sample_in(in_sample_in),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .clr_busy    (clr_busy),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  // decouples word intake from the store pipeline
  ggrr_queue #(
    .W(CMD_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .full     (q_full),
    .empty    (q_empty)
  );

  ggrr_back #(
    .GRAIN_COUNT  (GRAIN_COUNT),
    .MAX_GRAIN_LEN(MAX_GRAIN_LEN),
    .CMD_W        (CMD_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .clr_busy      (clr_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out)
  );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - granular grain ring resampler
// Self-checking bench: drives write and read words with random bursts and gaps,
// mirrors the grain ring in a local predictor, and checks every read result.
// ----------------------------------------------------------------------------
module tb;
  import ggrr_pkg::*;

  localparam int GRAINS     = DEF_GRAIN_COUNT;
  localparam int MAX_LEN    = DEF_MAX_GRAIN_LEN;
  localparam int NUM_PHASES = 12;
  localparam int LONG_HOLD  = 400;   // receiver hold-off, long enough to back up the pipe
  localparam int SETTLE     = 8;     // writes leave no result
  localparam int NUM_ROWS   = 25;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT pins (driven pins known from time zero)
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic                       in_kind      = KIND_WRITE;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       cfg_valid    = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index    = CFG_GRAIN_SIZE;
  logic [CFG_DAT_W-1:0]       cfg_data     = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  granular_grain_ring_resampler_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Grain ring predictor: its own copy of the store, pointers and registers
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] ring_mem [GRAINS*MAX_LEN];
  int unsigned wr_grain, wr_pos, rd_grain, rd_pos_q16;
  int unsigned gs_reg, speed_reg;

  logic signed [SAMPLE_W-1:0] expected_samples [$];
  int unsigned fail_count = 0;

  // Sender pacing and receiver hold-off handshake between processes
  bit          gaps_on = 1'b1;
  int unsigned burst_left = 0;
  int unsigned hold_requests = 0;

  function automatic void ring_reset();
    foreach (ring_mem[i]) ring_mem[i] = '0;
    wr_grain   = 0;
    wr_pos     = 0;
    rd_grain   = GRAINS - 1;
    rd_pos_q16 = 0;
    gs_reg     = GS_RESET;
    speed_reg  = SPEED_RESET;
  endfunction

  // Register value saturated into the legal grain length range
  function automatic int unsigned grain_len();
    if (gs_reg < MIN_GRAIN) return MIN_GRAIN;
    if (gs_reg > MAX_LEN) return MAX_LEN;
    return gs_reg;
  endfunction

  function automatic void ring_write(input logic signed [SAMPLE_W-1:0] s);
    int unsigned len, pos;
    len = grain_len();
    pos = wr_pos;
    if (pos >= MAX_LEN) pos = MAX_LEN - 1;
    if (wr_grain >= GRAINS) wr_grain = 0;
    ring_mem[wr_grain*MAX_LEN + pos] = s;
    // pointer may sit past a lowered grain size; it still wraps on the next write
    wr_pos = pos + 1;
    if (wr_pos >= len) begin
      wr_pos   = 0;
      wr_grain = (wr_grain + 1 >= GRAINS) ? 0 : wr_grain + 1;
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] interp_read();
    int unsigned len, cur, nxt, fr, base;
    longint      a, b, acc;
    len = grain_len();
    cur = rd_pos_q16 >> FRAC_W;
    fr  = rd_pos_q16 & 32'h0000_FFFF;
    if (cur >= MAX_LEN) cur = MAX_LEN - 1;
    // neighbor wraps inside the same grain
    nxt = cur + 1;
    if (nxt >= len) nxt -= len;
    if (nxt >= MAX_LEN) nxt = 0;
    if (rd_grain >= GRAINS) rd_grain = 0;
    base = rd_grain * MAX_LEN;
    a    = ring_mem[base + cur];
    b    = ring_mem[base + nxt];
    acc  = (longint'(65536) - longint'(fr)) * a + longint'(fr) * b;
    acc  = acc / 65536;   // truncates toward zero
    // step, subtracting one grain length at most
    rd_pos_q16 = ((cur << FRAC_W) | fr) + speed_reg;
    if ((rd_pos_q16 >> FRAC_W) >= len) begin
      rd_pos_q16 -= len << FRAC_W;
      rd_grain    = (rd_grain + 1 >= GRAINS) ? 0 : rd_grain + 1;
    end
    return acc[SAMPLE_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Leaves cfg_valid high; the caller drops it after the last register.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_GRAIN_SIZE) gs_reg = data[GS_REG_W-1:0];
    else speed_reg = data[SPEED_W-1:0];
  endtask

  // Offer one word, predict on acceptance, then maybe open a gap.
  // typed: use the hand-written expectation instead of the predicted one.
  task automatic push_word(input logic k, input logic signed [SAMPLE_W-1:0] s,
                           input bit typed, input logic signed [SAMPLE_W-1:0] want);
    logic signed [SAMPLE_W-1:0] pred;
    int unsigned gap;
    in_valid     <= 1'b1;
    in_kind      <= k;
    in_sample_in <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (k == KIND_READ) begin
      pred = interp_read();
      expected_samples.push_back(typed ? want : pred);
    end else begin
      ring_write(s);
    end
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(1, 8);
        in_valid  <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_results();
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: changing stall patterns, plus a long hold-off when requested
  // --------------------------------------------------------------------------
  int unsigned stall_mode = 0, mode_left = 0, hold_left = 0, holds_served = 0, pat_cnt = 0;

  always @(posedge clk) begin
    pat_cnt++;
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 128);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;                        // free running
        1:       out_stall <= ($urandom_range(0, 1) == 0); // coin flip
        2:       out_stall <= ($urandom_range(0, 3) != 0); // mostly stalled
        default: out_stall <= ((pat_cnt % 5) < 2);         // fixed rhythm
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: oldest expectation first
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_samples.size() == 0) begin
        $error("sample_out: no word expected, got %0d", out_sample_out);
        fail_count++;
      end else begin
        want = expected_samples.pop_front();
        if (out_sample_out !== want) begin
          $error("sample_out: expected %0d, got %0d", want, out_sample_out);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: clearing pass (32768 entries) plus worst-case pacing, many times over
  // --------------------------------------------------------------------------
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Directed rows. Setup: grain size 0 (saturates to 16), speed 4.0.
  // Reads 0-3 walk the untouched last grain (zeros) and roll into grain 0;
  // writes fill grain 0 with extremes; reads at integer positions return the
  // stored samples exactly; the final read lands in an untouched grain.
  // --------------------------------------------------------------------------
  typedef struct {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
    bit                         typed;
    logic signed [SAMPLE_W-1:0] want;
  } stim_row_t;

  stim_row_t dir_rows [NUM_ROWS] = '{
    '{KIND_READ,  16'sh1234, 1'b1, 16'sh0000},
    '{KIND_READ,  16'shFFFF, 1'b1, 16'sh0000},
    '{KIND_READ,  16'sh8000, 1'b1, 16'sh0000},
    '{KIND_READ,  16'sh7FFF, 1'b1, 16'sh0000},
    '{KIND_WRITE, 16'sh8000, 1'b0, 16'sh0000},   // pos 0
    '{KIND_WRITE, 16'sh7FFF, 1'b0, 16'sh0000},
    '{KIND_WRITE, 16'sh0000, 1'b0, 16'sh0000},
    '{KIND_WRITE, 16'shFFFF, 1'b0, 16'sh0000},
    '{KIND_WRITE, 16'sh0001, 1'b0, 16'sh0000},   // pos 4
    '{KIND_WRITE, 16'sh5555, 1'b0, 16'sh0000},
    '{KIND_WRITE, 16'shAAAA, 1'b0, 16'sh0000},
    '{KIND_WRITE, 16'sh0064, 1'b0, 16'sh0000},
    '{KIND_WRITE, 16'shFF9C, 1'b0, 16'sh0000},   // pos 8
    '{KIND_WRITE, 16'sh3039, 1'b0, 16'sh0000},
    '{KIND_WRITE, 16'shCFC7, 1'b0, 16'sh0000},
    '{KIND_WRITE, 16'sh0002, 1'b0, 16'sh0000},
    '{KIND_WRITE, 16'shFFFE, 1'b0, 16'sh0000},   // pos 12
    '{KIND_WRITE, 16'sh7FFE, 1'b0, 16'sh0000},
    '{KIND_WRITE, 16'sh8001, 1'b0, 16'sh0000},
    '{KIND_WRITE, 16'sh0007, 1'b0, 16'sh0000},   // grain 0 full
    '{KIND_READ,  16'sh0000, 1'b1, 16'sh8000},
    '{KIND_READ,  16'sh0000, 1'b1, 16'sh0001},
    '{KIND_READ,  16'sh0000, 1'b1, 16'shFF9C},
    '{KIND_READ,  16'sh0000, 1'b1, 16'shFFFE},
    '{KIND_READ,  16'sh0000, 1'b1, 16'sh0000}    // grain 1, never written
  };

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned ph, n, n_items, rd_pct, gs_pick, sp_pick;
    logic        k;
    logic signed [SAMPLE_W-1:0] s;

    ring_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // registers are taken during the clearing pass
    write_reg(CFG_GRAIN_SIZE, '0);
    write_reg(CFG_SPEED, 19'h40000);
    cfg_valid <= 1'b0;

    for (n = 0; n < NUM_ROWS; n++)
      push_word(dir_rows[n].kind, dir_rows[n].sample, dir_rows[n].typed, dir_rows[n].want);
    in_valid <= 1'b0;

    // Random phases. The first few are fixed so that a large grain is followed
    // by a tiny one, leaving both pointers past the new grain end.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();   // block idle before touching registers
      case (ph)
        0: begin gs_pick = 8191; sp_pick = 524287; end   // both at maximum
        1: begin gs_pick = 16;   sp_pick = 0;      end   // min size, frozen read
        2: begin gs_pick = 15;   sp_pick = 65536;  end   // below min, unit step
        3: begin gs_pick = 4096; sp_pick = $urandom_range(0, 524287); end
        default: begin
          case ($urandom_range(0, 7))
            0:       gs_pick = $urandom_range(0, 15);
            1:       gs_pick = 16;
            2, 3:    gs_pick = $urandom_range(16, 40);
            4:       gs_pick = $urandom_range(16, 300);
            5:       gs_pick = 4096;
            6:       gs_pick = $urandom_range(4097, 8191);
            default: gs_pick = $urandom_range(0, 8191);
          endcase
          case ($urandom_range(0, 5))
            0:       sp_pick = 0;
            1:       sp_pick = 524287;
            2:       sp_pick = 65536;
            3:       sp_pick = $urandom_range(1, 7) << FRAC_W;
            4:       sp_pick = $urandom_range(1, 131071);
            default: sp_pick = $urandom_range(0, 524287);
          endcase
        end
      endcase
      // unused upper data bits of the grain size word get random values
      write_reg(CFG_GRAIN_SIZE, {6'($urandom), 13'(gs_pick)});
      write_reg(CFG_SPEED, 19'(sp_pick));
      cfg_valid <= 1'b0;

      rd_pct  = $urandom_range(30, 70);
      gaps_on = (ph % 4 != 2);
      if (ph == 6) begin
        // long receiver hold while reads keep coming back to back
        hold_requests++;
        gaps_on = 1'b0;
        rd_pct  = 90;
      end

      n_items = $urandom_range(90, 110);
      for (n = 0; n < n_items; n++) begin
        k = ($urandom_range(0, 99) < rd_pct) ? KIND_READ : KIND_WRITE;
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0:       s = 16'sh8000;
            1:       s = 16'sh7FFF;
            2:       s = 16'sh0000;
            default: s = 16'shFFFF;
          endcase
        end else begin
          s = 16'($urandom);
        end
        push_word(k, s, 1'b0, '0);
      end
      in_valid <= 1'b0;
    end

    drain_results();
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
